// File: rtl/assert_macros.svh
// Assertion macros shared by the serial command framer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// File: rtl/scf_pkg.sv
// Types and constants shared by the serial command framer modules.
`timescale 1ns / 1ps

package scf_pkg;

    localparam logic [7:0] FRAME_START = 8'h02;
    localparam logic [7:0] FRAME_END   = 8'h03;

    typedef enum logic [1:0] {
        OP_ISSUE   = 2'd0,
        OP_BYTE    = 2'd1,
        OP_TIMEOUT = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        KIND_TX      = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_STATUS  = 2'd2,
        KIND_DISCARD = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD     = 2'd1,
        ST_TIMEOUT = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        JOB_PAYLOAD = 3'd0,
        JOB_FINAL   = 3'd1,
        JOB_OK_BYTE = 3'd2,
        JOB_FRAME   = 3'd3,
        JOB_RESEND  = 3'd4
    } job_kind_t;

    typedef struct packed {
        job_kind_t   jkind;
        logic [7:0]  data;
        status_t     status;
        logic [7:0]  command;
        logic [7:0]  length;
        logic [15:0] param;
    } job_t;

endpackage

// File: rtl/scf_front.sv
// Front end: accepts words, tracks the link state and issues output jobs.
`timescale 1ns / 1ps

module scf_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [3:0]        cfg_wr_data,
    input  logic              accept,
    input  logic [1:0]        op,
    input  logic [7:0]        command_code,
    input  logic [15:0]       param_word,
    input  logic [7:0]        reply_length,
    input  logic [7:0]        rx_byte,
    output logic              push,
    output scf_pkg::job_t     job
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_PAYLOAD
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  byte_count_reg, byte_count_next;
    logic [7:0]  payload_sum_reg, payload_sum_next;
    logic [3:0]  attempts_left_reg, attempts_left_next;
    logic [3:0]  max_attempts_reg;
    logic [7:0]  saved_command_reg, saved_command_next;
    logic [15:0] saved_param_reg, saved_param_next;
    logic [7:0]  saved_length_reg, saved_length_next;
    logic [7:0]  header_reg [6];
    logic        header_we;

    logic [7:0]  hb5;
    logic [7:0]  psum_check;
    logic [7:0]  hsum;
    logic        header_ok;
    logic        do_check;
    logic        has_byte;
    logic        do_fail;
    logic        start_frame;
    scf_pkg::status_t fail_reason;
    logic [8:0]  payload_count;

    assign hb5        = (phase_reg == PH_HEADER) ? rx_byte : header_reg[5];
    assign psum_check = (phase_reg == PH_PAYLOAD) ? payload_sum_reg + rx_byte
                                                  : payload_sum_reg;
    assign hsum       = header_reg[1] + header_reg[2] + header_reg[3];
    assign header_ok  = (header_reg[0] == scf_pkg::FRAME_START)
                     && (header_reg[1] == saved_command_reg)
                     && (header_reg[2] == saved_length_reg)
                     && (header_reg[3] == psum_check)
                     && (header_reg[4] == hsum)
                     && (hb5 == scf_pkg::FRAME_END);
    assign payload_count = {1'b0, byte_count_reg} + 9'd1;

    always_comb
    begin
        phase_next         = phase_reg;
        byte_count_next    = byte_count_reg;
        payload_sum_next   = payload_sum_reg;
        attempts_left_next = attempts_left_reg;
        saved_command_next = saved_command_reg;
        saved_param_next   = saved_param_reg;
        saved_length_next  = saved_length_reg;
        header_we          = 1'b0;
        do_check           = 1'b0;
        has_byte           = 1'b0;
        do_fail            = 1'b0;
        start_frame        = 1'b0;
        fail_reason        = scf_pkg::ST_BAD;
        push               = 1'b0;
        job                = '0;
        job.jkind          = scf_pkg::JOB_FINAL;
        job.status         = scf_pkg::ST_OK;

        if (accept)
        begin
            case (scf_pkg::op_t'(op))
                scf_pkg::OP_ISSUE:
                begin
                    saved_command_next = command_code;
                    saved_param_next   = param_word;
                    saved_length_next  = reply_length;
                    attempts_left_next = (max_attempts_reg == 4'd0) ? 4'd0
                                                                    : max_attempts_reg - 4'd1;
                    start_frame        = 1'b1;
                    push               = 1'b1;
                    job.jkind          = scf_pkg::JOB_FRAME;
                end
                scf_pkg::OP_BYTE:
                begin
                    case (phase_reg)
                        PH_HEADER:
                        begin
                            header_we       = 1'b1;
                            byte_count_next = byte_count_reg + 8'd1;
                            if (byte_count_reg == 8'd5)
                            begin
                                phase_next      = PH_PAYLOAD;
                                byte_count_next = 8'd0;
                                if (saved_length_reg == 8'd0)
                                begin
                                    do_check = 1'b1;
                                end
                            end
                        end
                        PH_PAYLOAD:
                        begin
                            payload_sum_next = payload_sum_reg + rx_byte;
                            byte_count_next  = payload_count[7:0];
                            if (payload_count >= {1'b0, saved_length_reg})
                            begin
                                do_check = 1'b1;
                                has_byte = 1'b1;
                            end
                            else
                            begin
                                push      = 1'b1;
                                job.jkind = scf_pkg::JOB_PAYLOAD;
                                job.data  = rx_byte;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                scf_pkg::OP_TIMEOUT:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        do_fail     = 1'b1;
                        fail_reason = scf_pkg::ST_TIMEOUT;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (do_check)
        begin
            if (header_ok)
            begin
                push            = 1'b1;
                job.jkind       = has_byte ? scf_pkg::JOB_OK_BYTE : scf_pkg::JOB_FINAL;
                job.data        = rx_byte;
                job.status      = scf_pkg::ST_OK;
                phase_next      = PH_IDLE;
                byte_count_next = 8'd0;
            end
            else
            begin
                do_fail     = 1'b1;
                fail_reason = scf_pkg::ST_BAD;
            end
        end

        if (do_fail)
        begin
            push       = 1'b1;
            job.status = fail_reason;
            if (attempts_left_reg != 4'd0)
            begin
                attempts_left_next = attempts_left_reg - 4'd1;
                job.jkind          = scf_pkg::JOB_RESEND;
                start_frame        = 1'b1;
            end
            else
            begin
                job.jkind       = scf_pkg::JOB_FINAL;
                phase_next      = PH_IDLE;
                byte_count_next = 8'd0;
            end
        end

        if (start_frame)
        begin
            phase_next       = PH_HEADER;
            byte_count_next  = 8'd0;
            payload_sum_next = 8'd0;
        end

        job.command = saved_command_next;
        job.length  = saved_length_next;
        job.param   = saved_param_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            byte_count_reg    <= 8'd0;
            payload_sum_reg   <= 8'd0;
            attempts_left_reg <= 4'd0;
            max_attempts_reg  <= 4'd3;
            saved_command_reg <= 8'd0;
            saved_param_reg   <= 16'd0;
            saved_length_reg  <= 8'd0;
        end
        else
        begin
            phase_reg         <= phase_next;
            byte_count_reg    <= byte_count_next;
            payload_sum_reg   <= payload_sum_next;
            attempts_left_reg <= attempts_left_next;
            saved_command_reg <= saved_command_next;
            saved_param_reg   <= saved_param_next;
            saved_length_reg  <= saved_length_next;
            if (cfg_wr_en)
            begin
                max_attempts_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (header_we)
        begin
            header_reg[byte_count_reg[2:0]] <= rx_byte;
        end
    end

endmodule

// File: rtl/scf_queue.sv
// Small job queue between the front end and the output sequencer.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module scf_queue #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  scf_pkg::job_t push_job,
    input  logic          pop,
    output scf_pkg::job_t head_job,
    output logic          not_empty,
    output logic          full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    scf_pkg::job_t  mem [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CW'(DEPTH));
    assign head_job  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    `ASSERT_IMPLY(a_no_push_full, clk, rst_n, push, !full)
    `ASSERT_IMPLY(a_no_pop_empty, clk, rst_n, pop, not_empty)
    `ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(DEPTH))
    `ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

// File: rtl/scf_back.sv
// Output sequencer: expands each job into output words behind an output register.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module scf_back (
    input  logic          clk,
    input  logic          rst_n,
    input  scf_pkg::job_t head_job,
    input  logic          not_empty,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [1:0]    kind,
    output logic [7:0]    byte_value,
    output logic [1:0]    status,
    output logic          last
);

    function automatic logic [3:0] word_total(input scf_pkg::job_kind_t jk);
        logic [3:0] n;
        case (jk)
            scf_pkg::JOB_OK_BYTE: n = 4'd2;
            scf_pkg::JOB_FRAME:   n = 4'd8;
            scf_pkg::JOB_RESEND:  n = 4'd9;
            default:              n = 4'd1;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] frame_byte(input scf_pkg::job_t j, input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = scf_pkg::FRAME_START;
            3'd1:    b = j.command;
            3'd2:    b = j.length;
            3'd3:    b = j.param[15:8];
            3'd4:    b = j.param[7:0];
            3'd5:    b = 8'd0;
            3'd6:    b = j.command + j.length + j.param[15:8] + j.param[7:0];
            default: b = scf_pkg::FRAME_END;
        endcase
        return b;
    endfunction

    scf_pkg::job_t    cur_job_reg;
    logic             cur_valid_reg;
    logic [3:0]       step_reg;
    logic             out_valid_reg;
    scf_pkg::kind_t   kind_reg, w_kind;
    logic [7:0]       byte_reg, w_byte;
    scf_pkg::status_t status_reg, w_status;
    logic             last_reg, w_last;

    logic             advance;
    logic             last_word;
    logic             load_cur;
    logic [2:0]       fstep;

    assign advance   = cur_valid_reg && (!out_valid_reg || !out_stall);
    assign last_word = (step_reg == word_total(cur_job_reg.jkind) - 4'd1);
    assign load_cur  = !cur_valid_reg || (advance && last_word);
    assign pop       = load_cur && not_empty;
    assign fstep     = (cur_job_reg.jkind == scf_pkg::JOB_RESEND) ? 3'(step_reg - 4'd1)
                                                                  : step_reg[2:0];

    always_comb
    begin
        w_kind   = scf_pkg::KIND_STATUS;
        w_byte   = 8'd0;
        w_status = scf_pkg::ST_OK;
        w_last   = last_word;
        case (cur_job_reg.jkind)
            scf_pkg::JOB_PAYLOAD:
            begin
                w_kind = scf_pkg::KIND_PAYLOAD;
                w_byte = cur_job_reg.data;
            end
            scf_pkg::JOB_OK_BYTE:
            begin
                if (step_reg == 4'd0)
                begin
                    w_kind = scf_pkg::KIND_PAYLOAD;
                    w_byte = cur_job_reg.data;
                end
            end
            scf_pkg::JOB_FRAME:
            begin
                w_kind = scf_pkg::KIND_TX;
                w_byte = frame_byte(cur_job_reg, fstep);
            end
            scf_pkg::JOB_RESEND:
            begin
                if (step_reg == 4'd0)
                begin
                    w_kind   = scf_pkg::KIND_DISCARD;
                    w_status = cur_job_reg.status;
                end
                else
                begin
                    w_kind = scf_pkg::KIND_TX;
                    w_byte = frame_byte(cur_job_reg, fstep);
                end
            end
            default:
            begin
                w_status = cur_job_reg.status;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            step_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_cur)
            begin
                cur_valid_reg <= not_empty;
                step_reg      <= 4'd0;
            end
            else if (advance)
            begin
                step_reg <= step_reg + 4'd1;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_job_reg <= head_job;
        end
        if (advance)
        begin
            kind_reg   <= w_kind;
            byte_reg   <= w_byte;
            status_reg <= w_status;
            last_reg   <= w_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign byte_value = byte_reg;
    assign status     = status_reg;
    assign last       = last_reg;

    `ASSERT_IMPLY(a_step_range, clk, rst_n, cur_valid_reg, step_reg < word_total(cur_job_reg.jkind))
    `ASSERT_IMPLY(a_status_last, clk, rst_n, out_valid_reg && kind_reg == scf_pkg::KIND_STATUS, last_reg)
    `ASSERT_IMPLY(a_discard_not_last, clk, rst_n, out_valid_reg && kind_reg == scf_pkg::KIND_DISCARD, !last_reg && status_reg != scf_pkg::ST_OK)

endmodule

// File: rtl/serial_command_framer.sv
// An accepted job passes the job queue, the current-job register and the output register.
// Throughput: one input word per cycle while the job queue has room; one output word per cycle unless stalled.
// A frame expands to 8 output words and a resend to 9, so bursts are paced by the sequencer.
// Reset clears the link state, the job queue and the output valid; max_attempts resets to 3.
// Header bytes hold no reset value and are written before they are checked, or bypassed from rx_byte.
`timescale 1ns / 1ps

module serial_command_framer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [7:0]  command_code,
    input  logic [15:0] param_word,
    input  logic [7:0]  reply_length,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  byte_value,
    output logic [1:0]  status,
    output logic        last
);

    logic          accept;
    logic          push;
    logic          pop;
    logic          q_not_empty;
    logic          q_full;
    scf_pkg::job_t push_job;
    scf_pkg::job_t head_job;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    scf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .accept       (accept),
        .op           (op),
        .command_code (command_code),
        .param_word   (param_word),
        .reply_length (reply_length),
        .rx_byte      (rx_byte),
        .push         (push),
        .job          (push_job)
    );

    scf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .head_job  (head_job),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    scf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_job   (head_job),
        .not_empty  (q_not_empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .byte_value (byte_value),
        .status     (status),
        .last       (last)
    );

endmodule
